// ===== rtl/dmrf_pkg.sv =====
// shared constants and types for the display mode register file
`timescale 1ns / 1ps

package dmrf_pkg;

    localparam int OFS_W     = 12;
    localparam int DATA_W    = 16;
    localparam int STRIDE_W  = 18;
    localparam int OFFSET_W  = 34;

    // register map, byte offsets
    localparam logic [OFS_W-1:0] OFS_ID      = 12'h500;
    localparam logic [OFS_W-1:0] OFS_XRES    = 12'h502;
    localparam logic [OFS_W-1:0] OFS_YRES    = 12'h504;
    localparam logic [OFS_W-1:0] OFS_BPP     = 12'h506;
    localparam logic [OFS_W-1:0] OFS_ENABLE  = 12'h508;
    localparam logic [OFS_W-1:0] OFS_VWIDTH  = 12'h50C;
    localparam logic [OFS_W-1:0] OFS_VHEIGHT = 12'h50E;
    localparam logic [OFS_W-1:0] OFS_XOFF    = 12'h510;
    localparam logic [OFS_W-1:0] OFS_YOFF    = 12'h512;
    localparam logic [OFS_W-1:0] OFS_VRAM    = 12'h514;
    localparam logic [OFS_W-1:0] OFS_EXTSIZE = 12'h600;
    localparam logic [OFS_W-1:0] OFS_ENDLO   = 12'h604;
    localparam logic [OFS_W-1:0] OFS_ENDHI   = 12'h606;

    localparam logic [DATA_W-1:0] VER_MIN     = 16'hB0C0;
    localparam logic [DATA_W-1:0] VER_MAX     = 16'hB0C5;
    localparam logic [DATA_W-1:0] CAPS_XRES   = 16'd2560;
    localparam logic [DATA_W-1:0] CAPS_YRES   = 16'd1440;
    localparam logic [DATA_W-1:0] BPP_VALUE   = 16'd32;
    localparam logic [DATA_W-1:0] EXT_SIZE    = 16'd8;
    localparam logic [DATA_W-1:0] ENDIAN_MARK = 16'h1E1E;
    localparam logic [DATA_W-1:0] VRAM_RESET  = 16'd256;

    // enable register bits
    localparam logic [7:0] EN_MASK    = 8'hE3;
    localparam int         EN_ON      = 0;
    localparam int         EN_CAPS    = 1;
    localparam int         EN_NOCLEAR = 7;

    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

endpackage

// ===== rtl/display_mode_register_file.sv =====
// top level of the display mode register file
`timescale 1ns / 1ps

// Register bank of a display mode interface with 16-bit registers in a 4 KiB window.
// Every access (read or write) is one input transfer and gives one result transfer.
// One access is taken per clock cycle while o_ready is high. The first stage decodes
// the offset, updates the mode registers and works out the stride; the second stage
// does the y_offset * stride multiply and adds x_offset. Every result carries the
// scanout description after that access. The VRAM size register is loaded through
// i_cfg_we / i_cfg_wdata and resets to 256.
module display_mode_register_file
    import dmrf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic [DATA_W-1:0]   i_cfg_wdata,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [OFS_W-1:0]    i_reg_offset,
    input  logic [DATA_W-1:0]   i_write_data,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_read_data,
    output logic                o_clear_vram,
    output logic                o_scanout_changed,
    output logic [DATA_W-1:0]   o_scanout_width,
    output logic [DATA_W-1:0]   o_scanout_height,
    output logic [STRIDE_W-1:0] o_scanout_stride,
    output logic [OFFSET_W-1:0] o_scanout_offset
);

    // mode registers
    logic [DATA_W-1:0] r_vram_units;
    logic [DATA_W-1:0] r_version,  n_version;
    logic [7:0]        r_enable,   n_enable;
    logic [DATA_W-1:0] r_xres,     n_xres;
    logic [DATA_W-1:0] r_yres,     n_yres;
    logic [DATA_W-1:0] r_vwidth,   n_vwidth;
    logic [DATA_W-1:0] r_vheight,  n_vheight;
    logic [DATA_W-1:0] r_xoff,     n_xoff;
    logic [DATA_W-1:0] r_yoff,     n_yoff;
    logic [DATA_W-1:0] r_awidth,   n_awidth;
    logic [DATA_W-1:0] r_aheight,  n_aheight;

    // first stage
    logic                r_s1_valid;
    logic [DATA_W-1:0]   r_s1_rd,     n_s1_rd;
    logic                r_s1_clr,    n_s1_clr;
    logic                r_s1_chg,    n_s1_chg;
    logic [STRIDE_W-1:0] r_s1_stride, n_s1_stride;
    logic [DATA_W-1:0]   r_s1_awidth;
    logic [DATA_W-1:0]   r_s1_aheight;
    logic [DATA_W-1:0]   r_s1_xoff;
    logic [DATA_W-1:0]   r_s1_yoff;

    // result stage
    logic                r_o_valid;
    logic [DATA_W-1:0]   r_o_rd;
    logic                r_o_clr;
    logic                r_o_chg;
    logic [DATA_W-1:0]   r_o_awidth;
    logic [DATA_W-1:0]   r_o_aheight;
    logic [STRIDE_W-1:0] r_o_stride;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [OFFSET_W-1:0] n_o_offset;

    logic                in_xfer;
    logic                s1_adv;
    logic                is_write;
    logic [STRIDE_W-1:0] width_bytes;
    logic [STRIDE_W-1:0] vwidth_ext;

    assign s1_adv   = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_s1_valid || s1_adv;
    assign in_xfer  = i_valid && o_ready;
    assign is_write = (t_kind'(i_kind) == KIND_WRITE);

    // register updates and read mux
    always_comb begin
        n_version = r_version;
        n_enable  = r_enable;
        n_xres    = r_xres;
        n_yres    = r_yres;
        n_vwidth  = r_vwidth;
        n_vheight = r_vheight;
        n_xoff    = r_xoff;
        n_yoff    = r_yoff;
        n_awidth  = r_awidth;
        n_aheight = r_aheight;
        n_s1_rd   = '0;
        n_s1_clr  = 1'b0;
        n_s1_chg  = 1'b0;
        if (is_write) begin
            case (i_reg_offset)
                OFS_ID: begin
                    n_version = i_write_data;
                end
                OFS_XRES: begin
                    if (!r_enable[EN_ON]) n_xres = i_write_data;
                end
                OFS_YRES: begin
                    if (!r_enable[EN_ON]) n_yres = i_write_data;
                end
                OFS_VWIDTH: begin
                    n_vwidth = i_write_data;
                    n_s1_chg = 1'b1;
                end
                OFS_VHEIGHT: begin
                    n_vheight = i_write_data;
                end
                OFS_XOFF: begin
                    n_xoff   = i_write_data;
                    n_s1_chg = 1'b1;
                end
                OFS_YOFF: begin
                    n_yoff   = i_write_data;
                    n_s1_chg = 1'b1;
                end
                OFS_ENABLE: begin
                    n_enable = i_write_data[7:0] & EN_MASK;
                    if (i_write_data[EN_ON]) begin
                        n_s1_clr  = !i_write_data[EN_NOCLEAR];
                        n_awidth  = r_xres;
                        n_aheight = r_yres;
                        n_s1_chg  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_reg_offset)
                OFS_ID: begin
                    if (r_version < VER_MIN || r_version > VER_MAX) n_s1_rd = VER_MAX;
                    else n_s1_rd = r_version;
                end
                OFS_XRES:    n_s1_rd = r_enable[EN_CAPS] ? CAPS_XRES : r_xres;
                OFS_YRES:    n_s1_rd = r_enable[EN_CAPS] ? CAPS_YRES : r_yres;
                OFS_BPP:     n_s1_rd = BPP_VALUE;
                OFS_ENABLE:  n_s1_rd = {8'd0, r_enable};
                OFS_VWIDTH:  n_s1_rd = r_vwidth;
                OFS_VHEIGHT: n_s1_rd = r_vheight;
                OFS_XOFF:    n_s1_rd = r_xoff;
                OFS_YOFF:    n_s1_rd = r_yoff;
                OFS_VRAM:    n_s1_rd = r_vram_units;
                OFS_EXTSIZE: n_s1_rd = EXT_SIZE;
                OFS_ENDLO:   n_s1_rd = ENDIAN_MARK;
                OFS_ENDHI:   n_s1_rd = ENDIAN_MARK;
                default:     n_s1_rd = '0;
            endcase
        end
    end

    // stride from the state after this access
    assign width_bytes = {n_awidth, 2'b00};
    assign vwidth_ext  = {2'b00, n_vwidth};
    assign n_s1_stride = (vwidth_ext > width_bytes) ? vwidth_ext : width_bytes;

    assign n_o_offset = OFFSET_W'(r_s1_yoff) * OFFSET_W'(r_s1_stride)
                      + OFFSET_W'(r_s1_xoff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vram_units <= VRAM_RESET;
        end else if (i_cfg_we) begin
            r_vram_units <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= '0;
            r_enable  <= '0;
            r_xres    <= '0;
            r_yres    <= '0;
            r_vwidth  <= '0;
            r_vheight <= '0;
            r_xoff    <= '0;
            r_yoff    <= '0;
            r_awidth  <= '0;
            r_aheight <= '0;
        end else if (in_xfer) begin
            r_version <= n_version;
            r_enable  <= n_enable;
            r_xres    <= n_xres;
            r_yres    <= n_yres;
            r_vwidth  <= n_vwidth;
            r_vheight <= n_vheight;
            r_xoff    <= n_xoff;
            r_yoff    <= n_yoff;
            r_awidth  <= n_awidth;
            r_aheight <= n_aheight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_xfer) r_s1_valid <= 1'b1;
            else if (s1_adv) r_s1_valid <= 1'b0;
            if (s1_adv) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_rd      <= n_s1_rd;
            r_s1_clr     <= n_s1_clr;
            r_s1_chg     <= n_s1_chg;
            r_s1_stride  <= n_s1_stride;
            r_s1_awidth  <= n_awidth;
            r_s1_aheight <= n_aheight;
            r_s1_xoff    <= n_xoff;
            r_s1_yoff    <= n_yoff;
        end
        if (s1_adv) begin
            r_o_rd      <= r_s1_rd;
            r_o_clr     <= r_s1_clr;
            r_o_chg     <= r_s1_chg;
            r_o_awidth  <= r_s1_awidth;
            r_o_aheight <= r_s1_aheight;
            r_o_stride  <= r_s1_stride;
            r_o_offset  <= n_o_offset;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_read_data       = r_o_rd;
    assign o_clear_vram      = r_o_clr;
    assign o_scanout_changed = r_o_chg;
    assign o_scanout_width   = r_o_awidth;
    assign o_scanout_height  = r_o_aheight;
    assign o_scanout_stride  = r_o_stride;
    assign o_scanout_offset  = r_o_offset;

endmodule

// ===== rtl/dmrf_checker.sv =====
// port-level checks for the display mode register file
`timescale 1ns / 1ps

module dmrf_checker
    import dmrf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [DATA_W-1:0]   o_read_data,
    input logic                o_clear_vram,
    input logic                o_scanout_changed,
    input logic [DATA_W-1:0]   o_scanout_width,
    input logic [STRIDE_W-1:0] o_scanout_stride,
    input logic [OFFSET_W-1:0] o_scanout_offset
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data)
            && $stable(o_scanout_offset))
        else $error("result changed while stalled");

    // stride never below the active width in bytes
    a_stride_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_scanout_stride >= {o_scanout_width, 2'b00})
        else $error("stride below width times four");

    // a clear request only comes with an enable that latches the scanout
    a_clear_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clear_vram |-> o_scanout_changed)
        else $error("clear request without scanout change");

    // a scanout change comes from a write, which reads as zero
    a_chg_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scanout_changed |-> o_read_data == '0)
        else $error("nonzero read data on a scanout change");

endmodule

bind display_mode_register_file dmrf_checker u_dmrf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_read_data       (o_read_data),
    .o_clear_vram      (o_clear_vram),
    .o_scanout_changed (o_scanout_changed),
    .o_scanout_width   (o_scanout_width),
    .o_scanout_stride  (o_scanout_stride),
    .o_scanout_offset  (o_scanout_offset)
);
